[hdl/integer_to_decimal_ascii_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the integer to decimal text converter
// Shared property wrappers, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define I2DA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a consequence in the next cycle.
`define I2DA_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[hdl/i2da_pkg.sv]
// ---------------------------------------------------------------------------
// i2da_pkg
// Types and constants of the integer to decimal text converter.
// ---------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned DIGITS   = 20;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned BITCNT_W = 7;
    localparam int unsigned DIGCNT_W = 5;

    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // Width codes carried with each item.
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[hdl/integer_to_decimal_ascii.sv]
// ---------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts an 8/16/32/64-bit signed or unsigned integer to its shortest
// decimal text, sent most significant character first.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Payload                                 | Marks
//  ---------+-----------+-----------------------------------------+--------
//  s_axis   | in        | tdata: value_bits, tuser: width, sign   | -
//  m_axis   | out       | tdata: char_code                        | tlast
//
// An item is converted with a shift-and-add-3 (double dabble) loop that
// takes one bit of the value per cycle: an item is loaded, its 8, 16, 32
// or 64 value bits are converted by its width, leading zero digits are
// dropped, and then one character (1 to 20 in all) is sent per cycle unless
// the output is stalled. The input is not ready until the last character
// of the previous item has been taken. Reset returns the sequencer to idle.
//
`default_nettype none

`include "integer_to_decimal_ascii_defines.svh"

module integer_to_decimal_ascii (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] value_bits
    input  wire logic [2:0]  s_tuser,   // [1:0] width_code, [2] is_signed
    // Output characters
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [5:0] char_code, [7:6] zero
    output logic             m_tlast    // last_char
);

    // Sequencer and counters.
    i2da_pkg::state_t                    state_reg, state_next;
    logic                                neg_reg,   neg_next;
    logic [i2da_pkg::BITCNT_W-1:0]       cnt_reg,   cnt_next;
    logic [i2da_pkg::DIGCNT_W-1:0]       ndig_reg,  ndig_next;

    // Binary bits still to be shifted in, and the BCD digit register.
    logic [i2da_pkg::VALUE_W-1:0]        bin_reg,   bin_next;
    logic [i2da_pkg::BCD_W-1:0]          bcd_reg,   bcd_next;

    // Load path.
    logic [1:0]                          width_code;
    logic                                is_signed;
    logic [i2da_pkg::VALUE_W-1:0]        mask;
    logic [i2da_pkg::VALUE_W-1:0]        sign_bit;
    logic [i2da_pkg::VALUE_W-1:0]        masked;
    logic [i2da_pkg::VALUE_W-1:0]        mag;
    logic                                load_neg;
    logic [i2da_pkg::VALUE_W-1:0]        load_bin;
    logic [i2da_pkg::BITCNT_W-1:0]       load_cnt;

    // Add-3 units, one per BCD digit, applied before the shift.
    logic [i2da_pkg::BCD_W-1:0]          bcd_adj;
    logic [3:0]                          top_digit;

    // Terms used by the checks at the end of the module.
    logic                                s_accept;
    logic                                char_minus;
    logic                                char_legal;

    assign width_code = s_tuser[1:0];
    assign is_signed  = s_tuser[2];
    assign top_digit  = bcd_reg[i2da_pkg::BCD_W-1 -: 4];

    // Mask the value to its width, take the magnitude, and left-align it so
    // the conversion loop always starts from bit 63.
    always_comb
    begin
        unique case (width_code)
            i2da_pkg::WIDTH_8:
            begin
                mask     = 64'h0000_0000_0000_00FF;
                sign_bit = 64'h0000_0000_0000_0080;
                load_cnt = 7'd8;
            end
            i2da_pkg::WIDTH_16:
            begin
                mask     = 64'h0000_0000_0000_FFFF;
                sign_bit = 64'h0000_0000_0000_8000;
                load_cnt = 7'd16;
            end
            i2da_pkg::WIDTH_32:
            begin
                mask     = 64'h0000_0000_FFFF_FFFF;
                sign_bit = 64'h0000_0000_8000_0000;
                load_cnt = 7'd32;
            end
            default:
            begin
                mask     = 64'hFFFF_FFFF_FFFF_FFFF;
                sign_bit = 64'h8000_0000_0000_0000;
                load_cnt = 7'd64;
            end
        endcase

        masked   = s_tdata & mask;
        load_neg = is_signed && ((masked & sign_bit) != '0);
        // The most negative value negates to 2^(width-1), which still fits.
        mag      = load_neg ? ((~(masked | ~mask)) + 64'd1) : masked;

        unique case (width_code)
            i2da_pkg::WIDTH_8:  load_bin = {mag[7:0],  56'd0};
            i2da_pkg::WIDTH_16: load_bin = {mag[15:0], 48'd0};
            i2da_pkg::WIDTH_32: load_bin = {mag[31:0], 32'd0};
            default:            load_bin = mag;
        endcase
    end

    // Add 3 to every digit of 5 or more; the digits are independent.
    always_comb
    begin
        for (int i = 0; i < i2da_pkg::DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Next state and outputs.
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        ndig_next  = ndig_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        m_tdata    = {2'b00, i2da_pkg::CHAR_ZERO + {2'b00, top_digit}};

        unique case (state_reg)
            i2da_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    neg_next   = load_neg;
                    cnt_next   = load_cnt;
                    bin_next   = load_bin;
                    bcd_next   = '0;
                    state_next = i2da_pkg::ST_CONVERT;
                end
            end

            i2da_pkg::ST_CONVERT:
            begin
                // One binary bit enters the BCD register per cycle.
                bcd_next = {bcd_adj[i2da_pkg::BCD_W-2:0], bin_reg[i2da_pkg::VALUE_W-1]};
                bin_next = {bin_reg[i2da_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    ndig_next  = i2da_pkg::DIGCNT_W'(i2da_pkg::DIGITS);
                    state_next = i2da_pkg::ST_SKIP;
                end
            end

            i2da_pkg::ST_SKIP:
            begin
                // Drop leading zeros, keeping at least one digit.
                if ((top_digit == 4'd0) && (ndig_reg != 5'd1))
                begin
                    bcd_next  = {bcd_reg[i2da_pkg::BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 5'd1;
                end
                else
                begin
                    state_next = i2da_pkg::ST_EMIT;
                end
            end

            i2da_pkg::ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (neg_reg)
                    m_tdata = {2'b00, i2da_pkg::CHAR_MINUS};
                else
                    m_tlast = (ndig_reg == 5'd1);
                if (m_tready)
                begin
                    if (neg_reg)
                        neg_next = 1'b0;
                    else if (ndig_reg == 5'd1)
                        state_next = i2da_pkg::ST_IDLE;
                    else
                    begin
                        bcd_next  = {bcd_reg[i2da_pkg::BCD_W-5:0], 4'd0};
                        ndig_next = ndig_reg - 5'd1;
                    end
                end
            end

            default:
            begin
                state_next = i2da_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2da_pkg::ST_IDLE;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            ndig_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
            ndig_reg  <= ndig_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign s_accept   = s_tvalid && s_tready;
    assign char_minus = (m_tdata[5:0] == i2da_pkg::CHAR_MINUS);
    assign char_legal = char_minus ||
                        ((m_tdata[5:0] >= i2da_pkg::CHAR_ZERO) &&
                         (m_tdata[5:0] <= (i2da_pkg::CHAR_ZERO + 6'd9)));

    // The block never takes an item while characters are being sent.
    `I2DA_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "input ready while sending text")

    // Every character is a digit or the minus sign.
    `I2DA_ASSERT(a_char_range, !m_tvalid || char_legal, "character out of range")

    // A minus sign is always followed by digits.
    `I2DA_ASSERT(a_minus_not_last, !(m_tvalid && char_minus && m_tlast), "minus sign marked last")

    // After an item is taken the converter is busy on the next cycle.
    `I2DA_ASSERT_NEXT(a_busy_after_load, s_accept, !s_tready && !m_tvalid, "not busy after load")

endmodule

`default_nettype wire
